// ----- rtl/core/sactl_pkg.sv -----
package sactl_pkg;

  localparam int unsigned NumWays  = 4;
  localparam int unsigned NumSets  = 64;
  localparam int unsigned WayW     = $clog2(NumWays);
  localparam int unsigned SetW     = $clog2(NumSets);
  localparam int unsigned AddrW    = 64;
  localparam int unsigned CntW     = 32;

  typedef enum logic [1:0] {
    CfgBlockBits = 2'd0,
    CfgSetBits   = 2'd1,
    CfgWaysInUse = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StUpdate
  } sactl_state_e;

  typedef struct packed {
    logic             op;
    logic [AddrW-1:0] addr;
  } req_t;

  typedef struct packed {
    logic             hit;
    logic             evict_valid;
    logic             evict_dirty;
    logic [AddrW-1:0] evict_addr;
    logic [CntW-1:0]  hits_total;
    logic [CntW-1:0]  misses_total;
    logic [CntW-1:0]  dirty_evictions;
    logic [CntW-1:0]  clean_evictions;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic update;
  } ctl_cmd_t;

endpackage

// ----- rtl/core/set_assoc_cache_tag_lru.sv -----
// Tag and LRU engine of a write-back set-associative cache (4 ways, 64 sets).
// Issue a request with start_i while busy_o is low; busy_o then stays high
// through the read and update states (lookup on the set row read at the
// accepting edge, then update). The result appears on result_o with done_o
// high for exactly one cycle, the cycle in which busy_o falls; it cannot be
// stalled, so the receiver must take it then.
// A new request may be issued in that same cycle. No new request is taken
// until the previous one has had its tag row read, looked up and written back.
// Configuration writes are always accepted and should only be made while idle.
module set_assoc_cache_tag_lru (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  sactl_pkg::req_t   req_i,
  output logic              busy_o,
  output logic              done_o,
  output sactl_pkg::rsp_t   result_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);

  // configuration registers
  logic [3:0] block_bits_q;
  logic [2:0] set_bits_q;
  logic [2:0] ways_in_use_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_bits_q  <= 4'd5;
      set_bits_q    <= 3'd6;
      ways_in_use_q <= 3'd4;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        sactl_pkg::CfgBlockBits: block_bits_q  <= cfg_data_i[3:0];
        sactl_pkg::CfgSetBits:   set_bits_q    <= cfg_data_i[2:0];
        sactl_pkg::CfgWaysInUse: ways_in_use_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  sactl_pkg::ctl_cmd_t cmd;

  // sequencer
  sactl_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .cmd_o   (cmd)
  );

  // lookup, replacement and counters
  sactl_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .req_i         (req_i),
    .block_bits_i  (block_bits_q),
    .set_bits_i    (set_bits_q),
    .ways_in_use_i (ways_in_use_q),
    .done_o        (done_o),
    .rsp_o         (result_o)
  );

  // a hit never reports an eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.hit |-> !result_o.evict_valid && !result_o.evict_dirty)
    else $error("eviction reported on hit");

  // a result follows every accepted request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##3 done_o)
    else $error("missing result");

  // dirty eviction implies valid eviction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.evict_dirty |-> result_o.evict_valid)
    else $error("dirty eviction of invalid line");

endmodule

// ----- rtl/core/sactl_ctrl.sv -----
module sactl_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  output sactl_pkg::ctl_cmd_t cmd_o
);

  sactl_pkg::sactl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sactl_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.update  = 1'b0;
    busy_o        = 1'b1;
    case (state_q)
      sactl_pkg::StIdle: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = sactl_pkg::StRead;
        end
      end
      sactl_pkg::StRead: begin
        state_d = sactl_pkg::StUpdate;
      end
      sactl_pkg::StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = sactl_pkg::StIdle;
      end
      default: begin
        state_d = sactl_pkg::StIdle;
      end
    endcase
  end

endmodule

// ----- rtl/core/sactl_dp.sv -----
module sactl_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sactl_pkg::ctl_cmd_t  cmd_i,
  input  sactl_pkg::req_t      req_i,
  input  logic [3:0]           block_bits_i,
  input  logic [2:0]           set_bits_i,
  input  logic [2:0]           ways_in_use_i,
  output logic                 done_o,
  output sactl_pkg::rsp_t      rsp_o
);

  localparam int unsigned WayW = sactl_pkg::WayW;
  localparam int unsigned SetW = sactl_pkg::SetW;
  localparam int unsigned NW   = sactl_pkg::NumWays;
  localparam int unsigned AW   = sactl_pkg::AddrW;
  localparam int unsigned CW   = sactl_pkg::CntW;

  // tag memory, one row per set holding all ways
  logic [NW-1:0][AW-1:0] tag_mem [sactl_pkg::NumSets];
  logic [NW-1:0][AW-1:0] tag_row_q;

  // metadata in flops, cleared by reset
  logic [sactl_pkg::NumSets-1:0][NW-1:0]           valid_q;
  logic [sactl_pkg::NumSets-1:0][NW-1:0]           dirty_q;
  logic [sactl_pkg::NumSets-1:0][NW-1:0][WayW-1:0] rank_q;

  logic [SetW-1:0]  set_q;
  logic [AW-1:0]    tag_q;
  logic             wr_q;
  logic [6:0]       shift_q;
  logic [3:0]       bb_q;
  logic [WayW:0]    ways_q;

  logic [CW-1:0] hits_q, misses_q, dirty_ev_q, clean_ev_q;

  logic [2:0]      s_eff;
  logic [6:0]      sh;
  logic [AW-1:0]   set_full;
  logic [WayW:0]   ways_eff;

  // metadata row of the set, copied at capture
  logic [NW-1:0]           vrow, drow;
  logic [NW-1:0][WayW-1:0] rrow;
  logic [NW-1:0][WayW-1:0] rank_nxt;
  logic                    hit;
  logic [WayW-1:0]         hway, inv_way, lru_way, victim, touched;
  logic                    inv_found;
  logic [AW-1:0]           ev_addr;

  always_comb begin
    s_eff = set_bits_i;
    if (32'(s_eff) > SetW) s_eff = 3'(SetW);
    ways_eff = (WayW+1)'(ways_in_use_i);
    if (ways_in_use_i == 3'd0) ways_eff = (WayW+1)'(1);
    if (32'(ways_in_use_i) > NW) ways_eff = (WayW+1)'(NW);
    sh       = 7'(s_eff) + 7'(block_bits_i);
    set_full = (req_i.addr >> block_bits_i) & ((64'd1 << s_eff) - 64'd1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      set_q     <= set_full[SetW-1:0];
      tag_q     <= (sh > 7'd63) ? '0 : (req_i.addr >> sh);
      wr_q      <= req_i.op;
      shift_q   <= sh;
      bb_q      <= block_bits_i;
      ways_q    <= ways_eff;
      tag_row_q <= tag_mem[set_full[SetW-1:0]];
      vrow      <= valid_q[set_full[SetW-1:0]];
      drow      <= dirty_q[set_full[SetW-1:0]];
      rrow      <= rank_q[set_full[SetW-1:0]];
    end
    if (cmd_i.update && !hit) begin
      tag_mem[set_q][victim] <= tag_q;
    end
  end

  always_comb begin
    hit       = 1'b0;
    hway      = '0;
    inv_found = 1'b0;
    inv_way   = '0;
    lru_way   = '0;
    for (int w = NW-1; w >= 0; w--) begin
      if ((WayW+1)'(w) < ways_q) begin
        if (vrow[w] && tag_row_q[w] == tag_q) begin
          hit  = 1'b1;
          hway = WayW'(w);
        end
        if (!vrow[w]) begin
          inv_found = 1'b1;
          inv_way   = WayW'(w);
        end
      end
    end
    for (int w = 1; w < NW; w++) begin
      if ((WayW+1)'(w) < ways_q && rrow[w] < rrow[lru_way]) lru_way = WayW'(w);
    end
    victim  = inv_found ? inv_way : lru_way;
    touched = hit ? hway : victim;
    // touched way becomes most recent, ways ranked above it move down
    for (int w = 0; w < NW; w++) begin
      rank_nxt[w] = (rrow[w] > rrow[touched]) ? rrow[w] - 1'b1 : rrow[w];
    end
    rank_nxt[touched] = WayW'(NW-1);
  end

  // a victim way that was never filled counts as a zero tag in the eviction address
  always_comb begin
    ev_addr = ((!vrow[victim] || shift_q > 7'd63) ? '0 : (tag_row_q[victim] << shift_q))
              | (64'(set_q) << bb_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      dirty_q    <= '0;
      rank_q     <= '0;
      hits_q     <= '0;
      misses_q   <= '0;
      dirty_ev_q <= '0;
      clean_ev_q <= '0;
      done_o     <= 1'b0;
    end else begin
      done_o <= cmd_i.update;
      if (cmd_i.update) begin
        rank_q[set_q] <= rank_nxt;
        if (hit) begin
          hits_q <= hits_q + 1'b1;
          if (wr_q) dirty_q[set_q][hway] <= 1'b1;
        end else begin
          misses_q <= misses_q + 1'b1;
          if (vrow[victim]) begin
            if (drow[victim]) dirty_ev_q <= dirty_ev_q + 1'b1;
            else clean_ev_q <= clean_ev_q + 1'b1;
          end
          valid_q[set_q][victim] <= 1'b1;
          dirty_q[set_q][victim] <= wr_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      rsp_o.hit             <= hit;
      rsp_o.evict_valid     <= !hit && vrow[victim];
      rsp_o.evict_dirty     <= !hit && drow[victim];
      rsp_o.evict_addr      <= hit ? '0 : ev_addr;
      rsp_o.hits_total      <= hits_q + CW'(hit);
      rsp_o.misses_total    <= misses_q + CW'(!hit);
      rsp_o.dirty_evictions <= dirty_ev_q + CW'(!hit && vrow[victim] && drow[victim]);
      rsp_o.clean_evictions <= clean_ev_q + CW'(!hit && vrow[victim] && !drow[victim]);
    end
  end

endmodule
